@@ sv/ptcs_pkg.sv @@
`default_nettype none
package ptcs_pkg;
    localparam int MAX_ORDER_DEF = 31;
    localparam int QW = 48;
    localparam logic signed [QW-1:0] Q_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [QW-1:0] Q_MIN = 48'sh8000_0000_0000;
    localparam logic signed [QW-1:0] START_STEP = 48'sh0064_0000_0000;

    localparam logic [1:0] CFG_ITER = 2'd0;
    localparam logic [1:0] CFG_TOL  = 2'd1;
    localparam logic [1:0] CFG_LEN  = 2'd2;

    typedef struct packed {
        logic signed [QW-1:0] coef;
        logic                 last;
    } qent_t;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_DIV, S_ITER0, S_HRD, S_HMUL, S_HADD, S_NDIV, S_NUPD, S_DONE, S_OUT
    } bst_t;

    function automatic logic signed [QW-1:0] sat49(input logic signed [QW:0] x);
        if (x > $signed({1'b0, Q_MAX})) return Q_MAX;
        if (x < $signed({1'b1, Q_MIN})) return Q_MIN;
        return x[QW-1:0];
    endfunction
endpackage
`default_nettype wire

@@ sv/polynomial_threshold_crossing_solver.sv @@
`default_nettype none
// Threshold-crossing solver for a voltage polynomial in Q16.32.
// Input channel: one coefficient word per handshake, order 0 first, peak_level
// sampled with the first word, is_last closing a load. Output channel: one
// word per load (crossing_time, not_converged, out_of_step).
// Words enter a two-entry queue; while idle, the back end stores one coefficient per cycle.
// After the last word a solve of order p above zero runs a setup step and the
// start division, then Newton steps: two products per coefficient on the
// shared multiplier, a divide and bookkeeping. The result then passes through
// a result register to the output register.
// The serial divider and multiplier set the rate; one load is solved at a time.
// While solving, the input stalls once the queue fills.
// Reset clears the load count, held peak, queue and output valid, and
// restores iteration_limit 50, step_tolerance 16 and step_length 2^30.
// A stalled output word holds; the next solve may run but cannot hand over
// its result until the held word is taken.
module polynomial_threshold_crossing_solver
    import ptcs_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [46:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic signed [QW-1:0] coefficient,
    input  wire logic signed [QW-1:0] peak_level,
    input  wire logic                 is_last,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic signed [QW-1:0]      crossing_time,
    output logic                      not_converged,
    output logic                      out_of_step
);
    logic [7:0]  iter_reg;
    logic [31:0] tol_reg;
    logic [46:0] len_reg;
    logic        q_valid, q_pop, first_seen;
    qent_t       q_data;
    logic signed [QW-1:0] peak_q_reg [2];
    logic        pw_reg, pr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= 8'd50;
            tol_reg  <= 32'd16;
            len_reg  <= 47'd1073741824;
            pw_reg   <= 1'b0;
            pr_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ITER: iter_reg <= cfg_data[7:0];
                    CFG_TOL:  tol_reg  <= cfg_data[31:0];
                    CFG_LEN:  len_reg  <= cfg_data;
                    default:  ;
                endcase
            end
            if (in_valid && !in_stall)
                pw_reg <= !pw_reg;
            if (q_pop)
                pr_reg <= !pr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            peak_q_reg[pw_reg] <= peak_level;
    end

    ptcs_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .coefficient, .is_last,
        .q_valid, .q_data, .q_pop
    );

    ptcs_back #(.MAX_ORDER(MAX_ORDER)) u_back (
        .clk, .rst_n, .q_valid, .q_data, .q_pop,
        .peak_in(peak_q_reg[pr_reg]), .first_flag(first_seen), .first_seen,
        .iter_limit(iter_reg), .tol(tol_reg), .len(len_reg),
        .out_valid, .out_stall, .crossing_time, .not_converged, .out_of_step
    );
endmodule
`default_nettype wire

@@ sv/ptcs_mul.sv @@
`default_nettype none
// Q16.32 multiply with round-half-away and saturation; one 24x24 partial product per cycle.
module ptcs_mul
    import ptcs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [QW-1:0] a,
    input  wire logic signed [QW-1:0] b,
    output logic                      done,
    output logic signed [QW-1:0]      p
);
    logic [47:0] ma_reg, mb_reg;
    logic        neg_reg;
    logic [95:0] acc_reg;
    logic [2:0]  cnt_reg;
    logic        busy_reg;
    logic [23:0] pa, pb;
    logic [47:0] pp;
    logic [95:0] sh;
    logic [95:0] rnd;
    logic [63:0] t;

    always_comb
    begin
        pa = cnt_reg[1] ? ma_reg[47:24] : ma_reg[23:0];
        pb = cnt_reg[0] ? mb_reg[47:24] : mb_reg[23:0];
        pp = 48'(pa) * 48'(pb);
        sh = 96'(pp) << (24 * (32'(cnt_reg[1]) + 32'(cnt_reg[0])));
        rnd = acc_reg + 96'h8000_0000;
        t = rnd[95:32];
        if (t >= 64'h8000_0000_0000)
            p = neg_reg ? Q_MIN : Q_MAX;
        else
            p = neg_reg ? -$signed(t[47:0]) : $signed(t[47:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                ma_reg   <= a[QW-1] ? 48'(-a) : 48'(a);
                mb_reg   <= b[QW-1] ? 48'(-b) : 48'(b);
                neg_reg  <= a[QW-1] ^ b[QW-1];
                acc_reg  <= '0;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_reg + sh;
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ sv/ptcs_div.sv @@
`default_nettype none
// Q16.32 restoring divider, one quotient bit per cycle over 80 bits of dividend.
module ptcs_div
    import ptcs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [QW-1:0] n,
    input  wire logic signed [QW-1:0] d,
    output logic                      done,
    output logic                      fault,
    output logic signed [QW-1:0]      q
);
    logic [79:0] num_reg;
    logic [48:0] rem_reg;
    logic [79:0] quo_reg;
    logic [47:0] md_reg;
    logic        neg_reg, busy_reg, zero_reg;
    logic [6:0]  cnt_reg;
    logic [48:0] r2;

    always_comb
    begin
        r2 = {rem_reg[47:0], num_reg[79]};
        fault = zero_reg;
        if (zero_reg)
            q = '0;
        else if (quo_reg >= 80'h8000_0000_0000)
            q = neg_reg ? Q_MIN : Q_MAX;
        else
            q = neg_reg ? -$signed(quo_reg[47:0]) : $signed(quo_reg[47:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            zero_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                num_reg  <= {(n[QW-1] ? 48'(-n) : 48'(n)), 32'd0};
                md_reg   <= d[QW-1] ? 48'(-d) : 48'(d);
                zero_reg <= (d == '0);
                neg_reg  <= n[QW-1] ^ d[QW-1];
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                num_reg <= num_reg << 1;
                if (r2 >= 49'(md_reg))
                begin
                    rem_reg <= r2 - 49'(md_reg);
                    quo_reg <= {quo_reg[78:0], 1'b1};
                end
                else
                begin
                    rem_reg <= r2;
                    quo_reg <= {quo_reg[78:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd79 || zero_reg)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ sv/ptcs_front.sv @@
`default_nettype none
// Accepts coefficient words into a two-entry queue.
module ptcs_front
    import ptcs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic signed [QW-1:0] coefficient,
    input  wire logic                 is_last,
    output logic                      q_valid,
    output qent_t                     q_data,
    input  wire logic                 q_pop
);
    qent_t       mem_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        push;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= '{coef: coefficient, last: is_last};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (q_pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end
endmodule
`default_nettype wire

@@ sv/ptcs_back.sv @@
`default_nettype none
// Stores coefficients and runs the Newton solve on the last word of a load.
module ptcs_back
    import ptcs_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire qent_t                q_data,
    output logic                      q_pop,
    input  wire logic signed [QW-1:0] peak_in,
    input  wire logic                 first_flag,
    output logic                      first_seen,
    input  wire logic [7:0]           iter_limit,
    input  wire logic [31:0]          tol,
    input  wire logic [46:0]          len,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic signed [QW-1:0]      crossing_time,
    output logic                      not_converged,
    output logic                      out_of_step
);
    localparam int AW = $clog2(MAX_ORDER + 1);
    localparam int CW = $clog2(MAX_ORDER + 2);

    logic signed [QW-1:0] store [MAX_ORDER + 1];
    logic [CW-1:0]        lc_reg;
    logic [AW-1:0]        p_reg, j_reg;
    logic signed [QW-1:0] rd_reg, c0_reg, c1_reg, cp_reg, peak_reg;
    logic signed [QW-1:0] t_reg, v_reg, dv_reg, dxo_reg, vm_reg;
    logic [7:0]           it_reg;
    logic                 ph_reg, nc_reg, oos_reg, ov_reg;
    logic signed [QW-1:0] ct_reg;
    logic signed [QW-1:0] out_ct_reg;
    logic                 out_nc_reg, out_oos_reg;
    bst_t                 st_reg, st_next;
    logic                 mstart, dstart, mdone, ddone, dfault;
    logic signed [QW-1:0] ma, mb, mp, dn, dd, dq;
    logic [AW-1:0]        widx;
    logic signed [QW-1:0] dx, tn, sdx, cj, dv_sum, v_sum;
    logic [QW-1:0]        mdx, msum;
    logic                 conv;

    ptcs_mul u_mul (.clk, .rst_n, .start(mstart), .a(ma), .b(mb), .done(mdone), .p(mp));
    ptcs_div u_div (.clk, .rst_n, .start(dstart), .n(dn), .d(dd), .done(ddone),
                    .fault(dfault), .q(dq));

    assign first_seen = (lc_reg == '0);
    assign widx = (lc_reg < CW'(MAX_ORDER)) ? lc_reg[AW-1:0] : AW'(MAX_ORDER);
    assign out_valid = ov_reg;
    assign crossing_time = out_ct_reg;
    assign not_converged = out_nc_reg;
    assign out_of_step = out_oos_reg;
    assign dx = dq;
    assign tn = sat49({t_reg[QW-1], t_reg} - {dx[QW-1], dx});
    assign sdx = sat49({dx[QW-1], dx} + {dxo_reg[QW-1], dxo_reg});
    assign mdx = dx[QW-1] ? -dx : dx;
    assign msum = sdx[QW-1] ? -sdx : sdx;
    assign conv = (mdx < QW'(tol)) || (msum < QW'(tol));
    // Coefficient 0 already has the peak taken off, so it comes from c0_reg.
    assign cj = (j_reg == '0) ? c0_reg : rd_reg;
    assign dv_sum = sat49({v_reg[QW-1], v_reg} + {vm_reg[QW-1], vm_reg});
    assign v_sum = sat49({cj[QW-1], cj} + {mp[QW-1], mp});

    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && q_valid)
            store[widx] <= q_data.coef;
        rd_reg <= store[j_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= S_IDLE;
        else
            st_reg <= st_next;
    end

    always_comb
    begin
        st_next = st_reg;
        q_pop = 1'b0;
        mstart = 1'b0;
        dstart = 1'b0;
        ma = ph_reg ? v_reg : dv_reg;
        mb = t_reg;
        dn = v_sum;
        dd = dv_sum;
        unique case (st_reg)
            S_IDLE:
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_data.last)
                        st_next = S_INIT;
                end
            S_INIT:
            begin
                dn = sat49(-{c0_reg[QW-1], c0_reg});
                dd = c1_reg;
                if (p_reg == '0)
                    st_next = S_DONE;
                else
                begin
                    dstart = 1'b1;
                    st_next = S_DIV;
                end
            end
            S_DIV:
                if (ddone)
                    st_next = dfault ? S_DONE : S_ITER0;
            S_ITER0:
                st_next = (it_reg == iter_limit) ? S_DONE : S_HRD;
            S_HRD:
            begin
                mstart = 1'b1;
                st_next = S_HMUL;
            end
            S_HMUL:
                if (mdone)
                    st_next = S_HADD;
            S_HADD:
                if (ph_reg && j_reg == '0)
                begin
                    dstart = 1'b1;
                    st_next = S_NDIV;
                end
                else
                    st_next = S_HRD;
            S_NDIV:
                if (ddone)
                    st_next = dfault ? S_DONE : S_NUPD;
            S_NUPD:
                st_next = conv ? S_DONE : S_ITER0;
            S_DONE:
                st_next = S_OUT;
            S_OUT:
                if (!ov_reg || !out_stall)
                    st_next = S_IDLE;
            default:
                st_next = S_IDLE;
        endcase
    end

    // Datapath for load and solve. Horner walk per coefficient: ph=0 forms dv*t, ph=1 forms v*t and updates both.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg   <= '0;
            peak_reg <= '0;
        end
        else
        begin
            unique case (st_reg)
                S_IDLE:
                    if (q_valid)
                    begin
                        if (first_flag)
                            peak_reg <= peak_in;
                        if (widx == '0)
                            c0_reg <= sat49({q_data.coef[QW-1], q_data.coef}
                                      - {(first_flag ? peak_in[QW-1] : peak_reg[QW-1]),
                                         (first_flag ? peak_in : peak_reg)});
                        if (widx == AW'(1))
                            c1_reg <= q_data.coef;
                        if (q_data.last)
                        begin
                            p_reg  <= widx;
                            cp_reg <= q_data.coef;
                            lc_reg <= '0;
                        end
                        else if (lc_reg < CW'(MAX_ORDER))
                            lc_reg <= lc_reg + CW'(1);
                        nc_reg  <= 1'b0;
                        oos_reg <= 1'b0;
                        it_reg  <= '0;
                        dxo_reg <= START_STEP;
                    end
                S_INIT:
                    if (p_reg == '0)
                        oos_reg <= 1'b1;
                S_DIV:
                    if (ddone)
                    begin
                        if (dfault)
                            oos_reg <= 1'b1;
                        t_reg <= dq;
                    end
                S_ITER0:
                    if (it_reg == iter_limit)
                        nc_reg <= 1'b1;
                    else
                    begin
                        v_reg  <= cp_reg;
                        dv_reg <= '0;
                        ph_reg <= 1'b0;
                        j_reg  <= p_reg - AW'(1);
                    end
                S_HADD:
                    if (!ph_reg)
                    begin
                        vm_reg <= mp;
                        ph_reg <= 1'b1;
                    end
                    else
                    begin
                        dv_reg <= dv_sum;
                        v_reg  <= v_sum;
                        ph_reg <= 1'b0;
                        if (j_reg != '0)
                            j_reg <= j_reg - AW'(1);
                    end
                S_NDIV:
                    if (ddone && dfault)
                        oos_reg <= 1'b1;
                S_NUPD:
                begin
                    t_reg   <= tn;
                    it_reg  <= it_reg + 8'd1;
                    dxo_reg <= dx;
                end
                S_DONE:
                begin
                    if (oos_reg || t_reg < 0 || t_reg > $signed({1'b0, len}))
                    begin
                        oos_reg <= 1'b1;
                        ct_reg  <= $signed({2'b00, len[46:1]});
                    end
                    else
                        ct_reg <= t_reg;
                end
                default:
                    ;
            endcase
        end
    end

    // The output word sits in its own register so the next load can proceed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg      <= 1'b0;
            out_ct_reg  <= '0;
            out_nc_reg  <= 1'b0;
            out_oos_reg <= 1'b0;
        end
        else if (st_reg == S_OUT && (!ov_reg || !out_stall))
        begin
            ov_reg      <= 1'b1;
            out_ct_reg  <= ct_reg;
            out_nc_reg  <= nc_reg;
            out_oos_reg <= oos_reg;
        end
        else if (!out_stall)
            ov_reg <= 1'b0;
    end
endmodule
`default_nettype wire

@@ bench/tb_polynomial_threshold_crossing_solver.sv @@
`default_nettype none
module tb_polynomial_threshold_crossing_solver;
    import ptcs_pkg::*;

    localparam longint QHI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint QLO = -64'sh0000_8000_0000_0000;
    localparam longint NEWTON_FIRST_STEP = 64'sd100 <<< 32;

    typedef struct {
        logic signed [QW-1:0] coef;
        logic signed [QW-1:0] peak;
        bit                   last;
    } coef_word_t;

    typedef struct {
        logic signed [QW-1:0] ct;
        bit                   nc;
        bit                   oos;
    } crossing_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [1:0]           cfg_index = CFG_ITER;
    logic [46:0]          cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic signed [QW-1:0] coefficient = '0;
    logic signed [QW-1:0] peak_level = '0;
    logic                 is_last = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [QW-1:0] crossing_time;
    logic                 not_converged;
    logic                 out_of_step;

    polynomial_threshold_crossing_solver u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .coefficient(coefficient), .peak_level(peak_level), .is_last(is_last),
        .out_valid(out_valid), .out_stall(out_stall),
        .crossing_time(crossing_time), .not_converged(not_converged),
        .out_of_step(out_of_step)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state and its copy of the registers.
    int     iter_limit = 50;
    longint tolerance = 16;
    longint step_len = 64'd1073741824;
    longint coef_mem [0:MAX_ORDER_DEF];
    int     words_loaded = 0;
    longint peak_held = 0;

    coef_word_t pending_words [$];
    crossing_t  expected_crossings [$];
    int         mismatches = 0;
    bit         sender_busy_mode = 1'b0;
    bit         receiver_busy_mode = 1'b0;
    bit         long_hold = 1'b0;

    function automatic longint clamp(longint x);
        if (x > QHI) return QHI;
        if (x < QLO) return QLO;
        return x;
    endfunction

    function automatic longint magnitude(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint apply_sign(logic [95:0] m, bit neg);
        if (m >= 96'h8000_0000_0000) return neg ? QLO : QHI;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        logic [95:0] p;
        p = 96'(magnitude(a)) * 96'(magnitude(b)) + 96'h8000_0000;
        return apply_sign(p >> 32, (a < 0) != (b < 0));
    endfunction

    function automatic longint fx_div(longint n, longint d, inout bit fault);
        logic [95:0] q;
        if (d == 0)
        begin
            fault = 1'b1;
            return 0;
        end
        q = (96'(magnitude(n)) << 32) / 96'(magnitude(d));
        return apply_sign(q, (n < 0) != (d < 0));
    endfunction

    // Newton solve over the stored coefficients of order p.
    function automatic crossing_t solve_crossing(int p);
        longint    c [0:MAX_ORDER_DEF];
        longint    t, v, dv, dx, dx_prev;
        bit        fault;
        bit        nc;
        int        i;
        crossing_t r;
        fault = 1'b0;
        nc = 1'b0;
        t = 0;
        for (i = 0; i <= p; i++)
            c[i] = coef_mem[i];
        c[0] = clamp(c[0] - peak_held);
        if (p == 0)
            fault = 1'b1;
        else
            t = fx_div(clamp(-c[0]), c[1], fault);
        if (!fault)
        begin
            dx_prev = NEWTON_FIRST_STEP;
            for (i = 0; i < iter_limit; i++)
            begin
                v = clamp(fx_mul(c[p], t) + c[p-1]);
                dv = c[p];
                for (int j = p - 2; j >= 0; j--)
                begin
                    dv = clamp(v + fx_mul(dv, t));
                    v = clamp(c[j] + fx_mul(v, t));
                end
                dx = fx_div(v, dv, fault);
                if (fault)
                    break;
                t = clamp(t - dx);
                if (magnitude(dx) < tolerance)
                    break;
                if (magnitude(clamp(dx + dx_prev)) < tolerance)
                    break;
                dx_prev = dx;
            end
            if (!fault && i == iter_limit)
                nc = 1'b1;
        end
        if (fault || t > step_len || t < 0)
        begin
            r.oos = 1'b1;
            t = step_len >> 1;
        end
        else
            r.oos = 1'b0;
        r.ct = t[QW-1:0];
        r.nc = nc;
        return r;
    endfunction

    function automatic void absorb_word(coef_word_t w);
        int idx;
        idx = words_loaded < MAX_ORDER_DEF ? words_loaded : MAX_ORDER_DEF;
        if (words_loaded == 0)
            peak_held = longint'(w.peak);
        coef_mem[idx] = longint'(w.coef);
        if (!w.last)
        begin
            if (words_loaded < MAX_ORDER_DEF)
                words_loaded++;
        end
        else
        begin
            words_loaded = 0;
            expected_crossings.push_back(solve_crossing(idx));
        end
    endfunction

    // Sender.
    int send_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                absorb_word('{coefficient, peak_level, is_last});
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    coef_word_t w;
                    w = pending_words.pop_front();
                    coefficient <= w.coef;
                    peak_level <= w.peak;
                    is_last <= w.last;
                    in_valid <= 1'b1;
                    send_gap <= sender_busy_mode ? 0 : $urandom_range(0, 18);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver and checker.
    int  rx_wait = 0;
    int  hold_cnt = 0;
    bit  hold_done = 1'b0;
    always @(posedge clk)
    begin
        int nw;
        int nh;
        crossing_t e;
        nw = rx_wait;
        nh = hold_cnt;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_crossings.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected word: crossing_time %0d nc %0b oos %0b",
                             $time, crossing_time, not_converged, out_of_step);
                end
                else
                begin
                    e = expected_crossings.pop_front();
                    if (crossing_time !== e.ct || not_converged !== e.nc ||
                        out_of_step !== e.oos)
                    begin
                        mismatches++;
                        $display("%0t: expected ct %0d nc %0b oos %0b, got ct %0d nc %0b oos %0b",
                                 $time, e.ct, e.nc, e.oos, crossing_time, not_converged,
                                 out_of_step);
                    end
                end
                nw = receiver_busy_mode ? 0 : $urandom_range(0, 18);
            end
            else if (nw > 0)
                nw--;
            if (nh > 0)
                nh--;
            else if (long_hold && !hold_done)
            begin
                nh = 3000;
                hold_done <= 1'b1;
            end
            rx_wait <= nw;
            hold_cnt <= nh;
            out_stall <= (nw != 0) || (nh != 0);
        end
    end

    function automatic logic signed [QW-1:0] rand_q();
        logic [QW-1:0] x;
        x = QW'({$urandom, $urandom});
        x = x >> $urandom_range(0, 47);
        return $urandom_range(0, 1) ? -x : x;
    endfunction

    function automatic void push_word(longint c, longint pk, bit last);
        pending_words.push_back('{c[QW-1:0], pk[QW-1:0], last});
    endfunction

    // kind 0: random coefficients; 1: line through a crossing in range;
    // 2: parabola through a crossing in range.
    function automatic void add_load(int kind, int order);
        longint pk, r, c1, c2, c0;
        pk = longint'(rand_q()) >>> $urandom_range(0, 12);
        if (kind == 0)
        begin
            for (int i = 0; i <= order; i++)
                push_word(rand_q(), rand_q(), i == order);
            return;
        end
        r = (longint'({$urandom, $urandom}) & QHI) % (step_len + 1);
        c1 = (longint'($urandom_range(1, 4095)) << 24) | $urandom_range(0, 65535);
        if ($urandom_range(0, 1))
            c1 = -c1;
        if (kind == 1)
        begin
            c0 = clamp(pk - fx_mul(c1, r));
            push_word(c0, pk, 1'b0);
            push_word(c1, rand_q(), 1'b1);
        end
        else
        begin
            c2 = longint'(rand_q()) >>> $urandom_range(8, 20);
            c0 = clamp(clamp(pk - fx_mul(c1, r)) - fx_mul(c2, fx_mul(r, r)));
            push_word(c0, pk, 1'b0);
            push_word(c1, rand_q(), 1'b0);
            push_word(c2, rand_q(), 1'b1);
        end
    endfunction

    task automatic write_reg(logic [1:0] idx, longint val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[46:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ITER: iter_limit = int'(val & 64'hFF);
            CFG_TOL:  tolerance = val & 64'hFFFF_FFFF;
            CFG_LEN:  step_len = val & QHI;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || expected_crossings.size() != 0 || in_valid)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_loads(int n_words, int max_noise_order, int noise_pct);
        int start;
        start = pending_words.size();
        while (pending_words.size() - start < n_words)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                add_load(0, $urandom_range(0, max_noise_order));
            else
                add_load($urandom_range(1, 2), 0);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: order zero, zero slope, extremes, an ordinary line and an ordinary parabola.
        push_word(rand_q(), rand_q(), 1'b1);
        push_word(QHI, 0, 1'b0);
        push_word(0, 0, 1'b1);
        push_word(QLO, QHI, 1'b0);
        push_word(QHI, QLO, 1'b1);
        push_word(QHI, QLO, 1'b0);
        push_word(QLO, QHI, 1'b0);
        push_word(QHI, 0, 1'b1);
        push_word(0, QLO, 1'b0);
        push_word(QLO, 0, 1'b1);
        push_word(-(64'sd1 <<< 32), 0, 1'b0);
        push_word(64'sd4 <<< 32, 0, 1'b1);
        push_word(0, 0, 1'b0);
        push_word(-(64'sd1 <<< 32), 0, 1'b0);
        push_word(64'sd1 <<< 32, 0, 1'b1);
        add_load(1, 0);
        add_load(2, 0);
        add_load(0, 3);
        drain();

        write_reg(CFG_ITER, 50);
        write_reg(CFG_TOL, 16);
        write_reg(CFG_LEN, 64'd1 << 30);
        random_loads(350, 4, 15);
        drain();

        sender_busy_mode = 1'b1;
        write_reg(CFG_ITER, 255);
        write_reg(CFG_TOL, 1);
        write_reg(CFG_LEN, QHI);
        for (int i = 0; i < 34; i++)
            push_word(rand_q() >>> 16, rand_q(), i == 33);
        random_loads(180, 3, 8);
        drain();

        sender_busy_mode = 1'b0;
        receiver_busy_mode = 1'b1;
        write_reg(CFG_ITER, 1);
        write_reg(CFG_TOL, 64'hFFFF_FFFF);
        write_reg(CFG_LEN, 1);
        random_loads(220, 6, 30);
        drain();

        receiver_busy_mode = 1'b0;
        write_reg(CFG_ITER, 0);
        write_reg(CFG_LEN, 0);
        random_loads(60, 8, 40);
        drain();

        // Receiver holds off while words keep coming, so the input backs up.
        sender_busy_mode = 1'b1;
        write_reg(CFG_ITER, 8);
        write_reg(CFG_TOL, $urandom_range(1, 65535));
        write_reg(CFG_LEN, (longint'($urandom) << 10) | 1);
        long_hold = 1'b1;
        random_loads(300, 4, 10);
        drain();

        sender_busy_mode = 1'b0;
        write_reg(CFG_ITER, $urandom_range(2, 30));
        write_reg(CFG_TOL, $urandom);
        write_reg(CFG_LEN, longint'({$urandom, $urandom}) & QHI);
        random_loads(200, 5, 20);
        drain();
        repeat (200) @(posedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
